// ===== src/cdm_pkg.sv =====
package cdm_pkg;

   // Default sizes
   localparam int DELAY_ENTRIES_DEF = 16384;
   localparam int SAMPLE_BITS_DEF   = 16;

   // Configuration registers
   localparam int MIX_DEPTH_W   = 16;
   localparam int TIME_STEP_W   = 32;
   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 32;
   localparam logic [MIX_DEPTH_W-1:0] MIX_DEPTH_RST = 16'd8192;
   localparam logic [TIME_STEP_W-1:0] TIME_STEP_RST = 32'd97391;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIX_DEPTH = 1'b0,
      CSR_TIME_STEP = 1'b1
   } csr_addr_type;

   // LFO phase: bit 32 is the second parity, bits 31..0 the fraction
   localparam int PHASE_W = 33;
   localparam int FRAC_W  = 32;
   localparam logic [PHASE_W-1:0] FRAC_ONE = 33'h1_0000_0000;

   // floor(q / 20) as (q * DIV20_RECIP) >> DIV20_SHIFT, exact for q < 2^18
   localparam int RECIP_W = 18;
   localparam logic [RECIP_W-1:0] DIV20_RECIP = 18'd209716;
   localparam int DIV20_SHIFT = 22;

   // Mixer: unity gain in Q2.14, denominator 16384 + depth
   localparam int UNITY_SHIFT = 14;
   localparam int DEN_W       = 17;
   localparam logic [DEN_W-1:0] UNITY_Q14 = 17'd16384;

endpackage

// ===== src/cdm_ram.sv =====
module cdm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/cdm_lfo.sv =====
// Triangle LFO to tap offset, two registered stages:
//   stage 1: triangle from phase, times DELAY_ENTRIES, keep the integer part
//   stage 2: divide that by 20 with a reciprocal multiply
module cdm_lfo #(
   parameter int DELAY_ENTRIES = cdm_pkg::DELAY_ENTRIES_DEF,
   localparam int AW = $clog2(DELAY_ENTRIES)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cdm_pkg::PHASE_W-1:0] phase,
   output logic                        done,
   output logic [AW-1:0]               offset
);

   localparam int QW    = $clog2(DELAY_ENTRIES + 1);
   localparam int PRODW = cdm_pkg::PHASE_W + QW;
   localparam int MW    = QW + cdm_pkg::RECIP_W;

   logic [cdm_pkg::PHASE_W-1:0] tri_w;
   logic [PRODW-1:0]            prod_w;
   logic [QW-1:0]               q_in;
   logic [QW-1:0]               q_ff;
   logic [MW-1:0]               m_w;
   logic [AW-1:0]               off_in;
   logic [AW-1:0]               off_ff;
   logic                        v1_ff;
   logic                        v2_ff;

   // falling half in even seconds, rising half in odd seconds
   always_comb begin
      if (phase[cdm_pkg::FRAC_W]) begin
         tri_w = {1'b0, phase[cdm_pkg::FRAC_W-1:0]};
      end else begin
         tri_w = cdm_pkg::FRAC_ONE - {1'b0, phase[cdm_pkg::FRAC_W-1:0]};
      end
      prod_w = PRODW'(tri_w) * PRODW'(DELAY_ENTRIES);
      q_in   = prod_w[cdm_pkg::FRAC_W +: QW];
   end

   always_comb begin
      m_w    = MW'(q_ff) * MW'(cdm_pkg::DIV20_RECIP);
      off_in = AW'(m_w >> cdm_pkg::DIV20_SHIFT);
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      off_ff <= off_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
      end
   end

   assign done   = v2_ff;
   assign offset = off_ff;

endmodule

// ===== src/cdm_div.sv =====
// Signed by unsigned division, truncated toward zero, one quotient bit per cycle.
// The numerator magnitude is at most den * 2^(SAMPLE_BITS-1), so its upper bits
// already form a remainder smaller than den and only SAMPLE_BITS steps are needed.
module cdm_div #(
   parameter int SAMPLE_BITS = cdm_pkg::SAMPLE_BITS_DEF,
   localparam int NUMW = SAMPLE_BITS + 18
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [NUMW-1:0]          num,
   input  logic [cdm_pkg::DEN_W-1:0]       den,
   output logic                            done,
   output logic signed [SAMPLE_BITS-1:0]   quo
);

   localparam int MW = NUMW - 1;
   localparam int CW = $clog2(SAMPLE_BITS + 1);
   localparam int DW = cdm_pkg::DEN_W;

   logic [MW-1:0]          mag_w;
   logic [DW-1:0]          rem_ff;
   logic [DW-1:0]          rem_in;
   logic [SAMPLE_BITS-1:0] sh_ff;
   logic [SAMPLE_BITS-1:0] sh_in;
   logic [DW-1:0]          den_ff;
   logic                   neg_ff;
   logic [CW-1:0]          cnt_ff;
   logic                   busy_ff;
   logic                   done_ff;
   logic [SAMPLE_BITS-1:0] quo_ff;
   logic [DW:0]            ext_w;
   logic [DW:0]            diff_w;
   logic                   ge_w;

   assign mag_w = num[NUMW-1] ? MW'(-num) : MW'(num);

   // one restoring step
   always_comb begin
      ext_w  = {rem_ff, sh_ff[SAMPLE_BITS-1]};
      diff_w = ext_w - {1'b0, den_ff};
      ge_w   = (ext_w >= {1'b0, den_ff});
      rem_in = ge_w ? diff_w[DW-1:0] : ext_w[DW-1:0];
      sh_in  = {sh_ff[SAMPLE_BITS-2:0], ge_w};
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DW'(mag_w >> SAMPLE_BITS);
         sh_ff  <= mag_w[SAMPLE_BITS-1:0];
         den_ff <= den;
         neg_ff <= num[NUMW-1];
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
         if (cnt_ff == CW'(1)) begin
            quo_ff <= neg_ff ? (~sh_in + 1'b1) : sh_in;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(SAMPLE_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// ===== src/chorus_delay_mixer_core.sv =====
// Chorus: each request carries one signed sample, which is written into a circular
// delay memory of DELAY_ENTRIES entries; a triangle LFO driven by a 33-bit phase
// accumulator (advanced by time_step per sample) picks a tap 0 to DELAY_ENTRIES/20
// samples back, and the response is (x*16384 + mix_depth*delayed)/(16384 + mix_depth),
// truncated toward zero. One request is processed at a time: it passes through the
// LFO, the memory read and the bit-serial divider, and the next request is taken
// only once the response has been loaded into the output register. A finished
// response sits in the output register, so the next request is taken while it waits.
// The delay memory needs no clearing pass after reset: a fill count makes taps that
// were never written read as zero. Configuration is written through csr_*; the user
// must write it only while no request is in flight, as the block does not enforce it.
module chorus_delay_mixer_core #(
   parameter int DELAY_ENTRIES = cdm_pkg::DELAY_ENTRIES_DEF,
   parameter int SAMPLE_BITS   = cdm_pkg::SAMPLE_BITS_DEF,
   localparam int TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // request: [SAMPLE_BITS-1:0] sample_in, zero padded
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [TDATA_W-1:0]             req_tdata,
   // response: [SAMPLE_BITS-1:0] mix_out, zero padded
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [TDATA_W-1:0]             rsp_tdata,
   // configuration writes
   input  logic                           csr_we,
   input  logic [cdm_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [cdm_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW   = $clog2(DELAY_ENTRIES);
   localparam int FW   = $clog2(DELAY_ENTRIES + 1);
   localparam int NUMW = SAMPLE_BITS + 18;
   localparam int SB   = SAMPLE_BITS;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LFO  = 5'b00010,
      ST_READ = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [cdm_pkg::MIX_DEPTH_W-1:0] depth_ff;
   logic [cdm_pkg::TIME_STEP_W-1:0] step_ff;
   logic [cdm_pkg::PHASE_W-1:0]     phase_ff;
   logic [AW-1:0]                   wp_ff, wp_in;
   logic [AW-1:0]                   wcur_ff;
   logic [FW-1:0]                   fill_ff, fill_in;
   logic signed [SB-1:0]            x_ff;
   logic                            lfo_go_ff;
   logic                            zero_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [SB-1:0]                   rsp_data_ff;

   logic                            accept_w;
   logic signed [SB-1:0]            sample_w;
   logic                            lfo_done;
   logic [AW-1:0]                   lfo_off;
   logic [AW-1:0]                   pos_w;
   logic [AW:0]                     wrap_w;
   logic                            rd_en_w;
   logic [SB-1:0]                   rd_data_w;
   logic signed [SB-1:0]            delayed_w;
   logic signed [SB+16:0]           wet_w;
   logic signed [NUMW-1:0]          num_w;
   logic [cdm_pkg::DEN_W-1:0]       den_w;
   logic                            div_start_w;
   logic                            div_done;
   logic signed [SB-1:0]            div_quo;
   logic                            rsp_load_w;

   assign accept_w   = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign sample_w   = $signed(req_tdata[SB-1:0]);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= cdm_pkg::MIX_DEPTH_RST;
         step_ff  <= cdm_pkg::TIME_STEP_RST;
      end else if (csr_we) begin
         case (csr_addr)
            cdm_pkg::CSR_MIX_DEPTH: depth_ff <= csr_wdata[cdm_pkg::MIX_DEPTH_W-1:0];
            cdm_pkg::CSR_TIME_STEP: step_ff  <= csr_wdata[cdm_pkg::TIME_STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // write pointer wrap and fill count saturation
   always_comb begin
      wp_in   = (wp_ff == AW'(DELAY_ENTRIES - 1)) ? '0 : wp_ff + 1'b1;
      fill_in = (fill_ff == FW'(DELAY_ENTRIES)) ? fill_ff : fill_ff + 1'b1;
   end

   // per-sample state: pointer, fill count, phase
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff     <= '0;
         fill_ff   <= '0;
         phase_ff  <= '0;
         lfo_go_ff <= 1'b0;
      end else begin
         lfo_go_ff <= accept_w;
         if (accept_w) begin
            wp_ff    <= wp_in;
            fill_ff  <= fill_in;
            phase_ff <= phase_ff + cdm_pkg::PHASE_W'(step_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_w) begin
         x_ff    <= sample_w;
         wcur_ff <= wp_ff;
      end
   end

   cdm_lfo #(
      .DELAY_ENTRIES(DELAY_ENTRIES)
   ) u_lfo (
      .clock (clock),
      .reset (reset),
      .start (lfo_go_ff),
      .phase (phase_ff),
      .done  (lfo_done),
      .offset(lfo_off)
   );

   // tap address, wrapping below zero
   always_comb begin
      wrap_w = (AW+1)'(wcur_ff) + (AW+1)'(DELAY_ENTRIES) - (AW+1)'(lfo_off);
      pos_w  = (wcur_ff >= lfo_off) ? (wcur_ff - lfo_off) : wrap_w[AW-1:0];
   end

   assign rd_en_w = (state_ff == ST_LFO) && lfo_done;

   // an entry older than the fill count was never written and reads as zero
   always_ff @(posedge clock) begin
      if (rd_en_w) begin
         zero_ff <= (FW'(lfo_off) >= fill_ff);
      end
   end

   cdm_ram #(
      .WIDTH(SB),
      .DEPTH(DELAY_ENTRIES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (accept_w),
      .wr_addr(wp_ff),
      .wr_data(sample_w),
      .rd_en  (rd_en_w),
      .rd_addr(pos_w),
      .rd_data(rd_data_w)
   );

   // dry plus weighted wet, and the normalizing denominator
   always_comb begin
      delayed_w = zero_ff ? '0 : $signed(rd_data_w);
      wet_w     = $signed({1'b0, depth_ff}) * delayed_w;
      num_w     = (NUMW'(x_ff) <<< cdm_pkg::UNITY_SHIFT) + NUMW'(wet_w);
      den_w     = cdm_pkg::UNITY_Q14 + cdm_pkg::DEN_W'(depth_ff);
   end

   assign div_start_w = (state_ff == ST_READ);

   cdm_div #(
      .SAMPLE_BITS(SB)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start_w),
      .num  (num_w),
      .den  (den_w),
      .done (div_done),
      .quo  (div_quo)
   );

   // sequencer
   assign rsp_load_w = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept_w) state_in = ST_LFO;
         ST_LFO:  if (lfo_done) state_in = ST_READ;
         ST_READ: state_in = ST_DIV;
         ST_DIV:  if (div_done) state_in = ST_OUT;
         ST_OUT:  if (rsp_load_w) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load_w) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load_w) begin
         rsp_data_ff <= div_quo;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);

endmodule

// ===== src/cdm_checker.sv =====
module cdm_checker #(
   parameter int TDATA_W = 16
) (
   input logic               clock,
   input logic               reset,
   input logic               req_tvalid,
   input logic               req_tready,
   input logic               rsp_tvalid,
   input logic               rsp_tready,
   input logic [TDATA_W-1:0] rsp_tdata
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // ready to take a request right after reset
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("not ready after reset");

   // one request in flight at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

   // a new response only comes out of a busy cycle
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without a request in flight");

endmodule

bind chorus_delay_mixer_core cdm_checker #(.TDATA_W(TDATA_W)) u_cdm_checker (.*);

// ===== tb/chorus_mix_checker.sv =====
// Watches the request, response and CSR ports of the chorus core, predicts every
// mixed sample from its own copy of the delay line and LFO, and compares in order.
module chorus_mix_checker
   import cdm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] sample_in
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,   // [15:0] mix_out
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding
);

   localparam int SW      = SAMPLE_BITS_DEF;
   localparam int ENTRIES = DELAY_ENTRIES_DEF;
   localparam int PTR_W   = $clog2(ENTRIES);

   // shadow state of the chorus
   logic signed [SW-1:0]      delay_line [ENTRIES];
   logic [PTR_W-1:0]          wr_ptr;
   logic [PHASE_W-1:0]        lfo_acc;
   logic [MIX_DEPTH_W-1:0]    depth_reg;
   logic [TIME_STEP_W-1:0]    step_reg;

   // mixed samples still owed by the core, oldest first
   logic [SW-1:0]             expected_mix_q [$];

   // store the sample, advance the LFO, read the swept tap and mix
   function automatic logic [SW-1:0] predict_mix(input logic signed [SW-1:0] x);
      logic [PHASE_W-1:0]   tri_val;
      longint unsigned      tap_back;
      logic [PTR_W-1:0]     tap_pos;
      logic signed [SW-1:0] delayed;
      longint               num;
      longint               den;
      delay_line[wr_ptr] = x;
      lfo_acc = lfo_acc + {1'b0, step_reg};
      // triangle: falling in even seconds, rising in odd ones
      tri_val = lfo_acc[FRAC_W] ? {1'b0, lfo_acc[FRAC_W-1:0]}
                                : FRAC_ONE - {1'b0, lfo_acc[FRAC_W-1:0]};
      tap_back = (64'(tri_val) * ENTRIES) / (64'd20 << FRAC_W);
      tap_pos  = wr_ptr - PTR_W'(tap_back);
      delayed  = delay_line[tap_pos];
      wr_ptr   = wr_ptr + 1'b1;
      num = longint'(x) * 64'sd16384 + longint'(depth_reg) * longint'(delayed);
      den = 64'sd16384 + longint'(depth_reg);
      return SW'(num / den);
   endfunction

   always @(posedge clock) begin
      logic [SW-1:0] want;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) delay_line[i] = '0;
         wr_ptr    = '0;
         lfo_acc   = '0;
         depth_reg = MIX_DEPTH_RST;
         step_reg  = TIME_STEP_RST;
         expected_mix_q.delete();
         fail_count = 0;
      end else begin
         // responses first: a request taken at this edge is never answered at it
         if (rsp_tvalid && rsp_tready) begin
            if (expected_mix_q.size() == 0) begin
               $error("mix_out: expected nothing, actual %0d", $signed(rsp_tdata[SW-1:0]));
               fail_count++;
            end else begin
               want = expected_mix_q.pop_front();
               if (rsp_tdata[SW-1:0] !== want) begin
                  $error("mix_out: expected %0d, actual %0d",
                         $signed(want), $signed(rsp_tdata[SW-1:0]));
                  fail_count++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_mix_q.push_back(predict_mix(req_tdata[SW-1:0]));
         if (csr_we) begin
            case (csr_addr)
               CSR_MIX_DEPTH: depth_reg = csr_wdata[MIX_DEPTH_W-1:0];
               CSR_TIME_STEP: step_reg  = csr_wdata[TIME_STEP_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding = expected_mix_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import cdm_pkg::*;

   localparam int SW = SAMPLE_BITS_DEF;
   localparam int DW = ((SW + 7) / 8) * 8;
   // brings the phase from five reset-rate steps up to exactly one second
   localparam logic [31:0] ALIGN_STEP = 32'h0 - 32'(5 * TIME_STEP_RST);

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DW-1:0]         req_tdata = '0;    // [15:0] sample_in
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DW-1:0]         rsp_tdata;         // [15:0] mix_out
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = CSR_MIX_DEPTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int outstanding;
   bit no_idle = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   chorus_delay_mixer_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   chorus_mix_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // one request after a random gap; valid stays up when the gap is zero
   task automatic send_request(input logic [SW-1:0] s);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = DW'(s);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // hold off until every mixed sample is back, so the core is idle
   task automatic drain();
      req_tvalid = 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
   endtask

   task automatic write_csr(input csr_addr_type a, input logic [CSR_DATA_W-1:0] v);
      csr_we    = 1'b1;
      csr_addr  = a;
      csr_wdata = v;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   function automatic logic [SW-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         default: return SW'($urandom);
      endcase
   endfunction

   // response side: random stall per response, none in no-idle stretches
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      logic [CSR_DATA_W-1:0] depth_val;
      logic [CSR_DATA_W-1:0] step_val;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings, full-scale corners
      send_request(16'h7FFF);
      send_request(16'h8000);
      send_request(16'h0000);
      send_request(16'hFFFF);
      send_request(16'h0001);

      // max depth; land on a whole second, then half-second steps:
      // odd second gives a zero tap, the wrap to even second hits the peak tap
      drain();
      write_csr(CSR_MIX_DEPTH, 32'd32768);
      write_csr(CSR_TIME_STEP, ALIGN_STEP);
      send_request(16'h7FFF);
      drain();
      write_csr(CSR_TIME_STEP, 32'h8000_0000);
      send_request(16'h8000);
      send_request(16'h7FFF);
      send_request(16'h8000);
      send_request(16'h7FFF);

      // dry only, frozen LFO
      drain();
      write_csr(CSR_MIX_DEPTH, 32'd0);
      write_csr(CSR_TIME_STEP, 32'd0);
      send_request(16'h7FFF);
      send_request(16'h8000);
      send_request(16'h5555);
      send_request(16'hAAAA);

      // depth beyond range, largest step (phase wraps)
      drain();
      write_csr(CSR_MIX_DEPTH, 32'h0000_FFFF);
      write_csr(CSR_TIME_STEP, 32'hFFFF_FFFF);
      send_request(16'h7FFF);
      send_request(16'h8000);
      send_request(16'hFFFF);
      send_request(16'h0001);
      send_request(16'h7FFF);
      send_request(16'h8000);

      // smallest nonzero settings
      drain();
      write_csr(CSR_MIX_DEPTH, 32'd1);
      write_csr(CSR_TIME_STEP, 32'd1);
      send_request(16'h8000);
      send_request(16'h7FFF);
      send_request(16'h0000);

      // random phases, each with its own settings
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case ($urandom_range(0, 4))
            0:       depth_val = 32'd0;
            1:       depth_val = 32'd32768;
            2:       depth_val = 32'h0000_FFFF;
            3:       depth_val = $urandom_range(0, 32768);
            default: depth_val = {16'h0, 16'($urandom)};
         endcase
         case ($urandom_range(0, 5))
            0:       step_val = 32'd0;
            1:       step_val = 32'h8000_0000;
            2:       step_val = $urandom_range(1, 4096);
            3:       step_val = $urandom;
            default: step_val = $urandom_range(32'h0040_0000, 32'h1000_0000);
         endcase
         write_csr(CSR_MIX_DEPTH, depth_val);
         write_csr(CSR_TIME_STEP, step_val);
         no_idle = (ph == 2);
         repeat (113) send_request(random_sample());
      end
      req_tvalid = 1'b0;
      no_idle    = 1'b0;

      wait (outstanding == 0);
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== sim.f =====
src/cdm_pkg.sv
src/cdm_ram.sv
src/cdm_lfo.sv
src/cdm_div.sv
src/chorus_delay_mixer_core.sv
src/cdm_checker.sv
tb/chorus_mix_checker.sv
tb/tb_top.sv
